[rtl/ctd_pkg.sv]
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared widths, face codes and stage payload types of the cube texel
// direction block.
// ----------------------------------------------------------------------------
package ctd_pkg;

   // Field widths
   localparam int COORD_W    = 11;   // texel column / row
   localparam int FACE_SEL_W = 3;    // face code
   localparam int FACE_W     = 12;   // face_size register
   localparam int DIR_W      = 16;   // Q1.15 direction
   localparam int WT_W       = 16;   // Q0.16 weight

   localparam int MAX_FACE_SIZE = 2048;
   localparam int FACE_SIZE_RST = 256;

   // Vector setup
   localparam int COMP_W = 14;       // signed vector component
   localparam int MAG_W  = 12;       // component magnitude
   localparam int SQ_W   = 2 * MAG_W;
   localparam int SUM_W  = 26;       // x^2 + y^2 + z^2

   // Root chain: t = floor(sqrt(N / s)), one result bit per cell
   localparam int NUM_CELLS    = 18;
   localparam int ROOT_W       = NUM_CELLS;
   localparam int FEED_W       = 2 * NUM_CELLS;  // low bits of N fed two per cell
   localparam int RES_W        = 48;             // remainder and s*t accumulator
   localparam int COMP_SHIFT   = 32;             // N = m^2 << 32 for a direction
   localparam int WEIGHT_SHIFT = 34;             // N = w^2 << 34 for the weight

   localparam int NUM_DIRS    = 3;
   localparam int NUM_LANES   = NUM_DIRS + 1;
   localparam int LANE_WEIGHT = NUM_DIRS;

   localparam logic [DIR_W-1:0] DIR_POS_MAX = {1'b0, {(DIR_W-1){1'b1}}};
   localparam logic [WT_W-1:0]  WT_MAX      = {WT_W{1'b1}};

   typedef enum logic [FACE_SEL_W-1:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   // One square-root lane in flight
   typedef struct packed {
      logic [RES_W-1:0]  rem;    // scaled remainder of N - t^2 * s
      logic [RES_W-1:0]  acc;    // s * t so far
      logic [ROOT_W-1:0] root;   // t so far
      logic [FEED_W-1:0] feed;   // bits of N not yet brought in
   } lane_type;

   // Payload handed from cell to cell
   typedef struct packed {
      logic [SUM_W-1:0]                sum_sq;
      lane_type [NUM_LANES-1:0]        lane;
      logic [NUM_DIRS-1:0]             neg;
      logic                            bad;
   } cell_data_type;

endpackage

[rtl/ctd_if.sv]
// ----------------------------------------------------------------------------
// ctd_if
// Valid/ready channels of the cube texel direction block: texel requests,
// direction results and the face_size write port.
// ----------------------------------------------------------------------------
interface ctd_req_if;
   import ctd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COORD_W-1:0]    texel_col;
   logic [COORD_W-1:0]    texel_row;
   logic [FACE_SEL_W-1:0] face;

   modport source (output valid, output texel_col, output texel_row, output face,
                   input ready);
   modport sink   (input valid, input texel_col, input texel_row, input face,
                   output ready);
endinterface

interface ctd_rsp_if;
   import ctd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [DIR_W-1:0] dir_x;
   logic signed [DIR_W-1:0] dir_y;
   logic signed [DIR_W-1:0] dir_z;
   logic [WT_W-1:0]         solid_weight;
   logic                    bad_face;

   modport source (output valid, output dir_x, output dir_y, output dir_z,
                   output solid_weight, output bad_face, input ready);
   modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                   input solid_weight, input bad_face, output ready);
endinterface

interface ctd_csr_if;
   import ctd_pkg::*;
   logic              valid;
   logic              ready;
   logic [FACE_W-1:0] face_size;

   modport source (output valid, output face_size, input ready);
   modport sink   (input valid, input face_size, output ready);
endinterface

[rtl/ctd_front.sv]
// ----------------------------------------------------------------------------
// ctd_front
// Three-stage setup: builds the texel-centre vector for the face, squares the
// components, then forms s = x^2 + y^2 + z^2 and the starting lane state of
// the root chain.
// ----------------------------------------------------------------------------
module ctd_front (
   input  logic                         clock,
   input  logic                         reset,
   ctd_req_if.sink                      req,
   input  logic [ctd_pkg::FACE_W-1:0]   face_size,
   output logic                         out_valid,
   input  logic                         out_ready,
   output ctd_pkg::cell_data_type       out_data
);
   import ctd_pkg::*;

   // Stage A: vector
   logic                           a_valid_ff;
   logic [NUM_DIRS-1:0][MAG_W-1:0] a_mag_ff, a_mag_in;
   logic [NUM_DIRS-1:0]            a_neg_ff, a_neg_in;
   logic [FACE_W-1:0]              a_w_ff, a_w_in;
   logic                           a_bad_ff, a_bad_in;
   logic                           a_ready;

   // Stage B: squares
   logic                           b_valid_ff;
   logic [NUM_DIRS-1:0][SQ_W-1:0]  b_sq_ff, b_sq_in;
   logic [SQ_W-1:0]                b_wsq_ff, b_wsq_in;
   logic [NUM_DIRS-1:0]            b_neg_ff;
   logic                           b_bad_ff;
   logic                           b_ready;

   // Stage C: sum and lane start
   logic                           c_valid_ff;
   cell_data_type                  c_data_ff, c_data_in;
   logic                           c_ready;

   logic signed [COMP_W-1:0]               a_val, b_val, w_val;
   logic signed [NUM_DIRS-1:0][COMP_W-1:0] vec;
   logic [SUM_W-1:0]                       sum;

   // Ready chain: a stage loads when empty or when its contents move on
   assign c_ready   = !c_valid_ff || out_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req.ready = a_ready;

   // Stage A next: a = 2*col - w + 1, b = w - 2*row - 1, per-face swizzle
   always_comb begin
      a_w_in = (face_size > FACE_W'(MAX_FACE_SIZE)) ? FACE_W'(MAX_FACE_SIZE) : face_size;
      w_val  = $signed({{(COMP_W-FACE_W){1'b0}}, a_w_in});
      a_val  = $signed({{(COMP_W-COORD_W-1){1'b0}}, req.texel_col, 1'b0}) - w_val
               + COMP_W'(1);
      b_val  = w_val - $signed({{(COMP_W-COORD_W-1){1'b0}}, req.texel_row, 1'b0})
               - COMP_W'(1);
      a_bad_in = 1'b0;
      case (face_type'(req.face))
         FACE_POS_X: begin
            vec[0] = w_val;   vec[1] = b_val;   vec[2] = -a_val;
         end
         FACE_NEG_X: begin
            vec[0] = -w_val;  vec[1] = b_val;   vec[2] = a_val;
         end
         FACE_POS_Y: begin
            vec[0] = a_val;   vec[1] = w_val;   vec[2] = -b_val;
         end
         FACE_NEG_Y: begin
            vec[0] = a_val;   vec[1] = -w_val;  vec[2] = b_val;
         end
         FACE_POS_Z: begin
            vec[0] = a_val;   vec[1] = b_val;   vec[2] = w_val;
         end
         FACE_NEG_Z: begin
            vec[0] = -a_val;  vec[1] = b_val;   vec[2] = -w_val;
         end
         default: begin
            vec      = '0;
            a_bad_in = 1'b1;
         end
      endcase
      for (int i = 0; i < NUM_DIRS; i++) begin
         a_neg_in[i] = vec[i][COMP_W-1];
         a_mag_in[i] = a_neg_in[i] ? MAG_W'(-vec[i]) : MAG_W'(vec[i]);
      end
   end

   // Stage B next: squares of the magnitudes and of w
   always_comb begin
      for (int i = 0; i < NUM_DIRS; i++) begin
         b_sq_in[i] = a_mag_ff[i] * a_mag_ff[i];
      end
      b_wsq_in = SQ_W'(a_w_ff) * SQ_W'(a_w_ff);
   end

   // Stage C next: s and the starting remainder / feed bits of each lane
   always_comb begin
      sum = SUM_W'(b_sq_ff[0]) + SUM_W'(b_sq_ff[1]) + SUM_W'(b_sq_ff[2]);
      c_data_in.sum_sq = (b_bad_ff || sum == '0) ? SUM_W'(1) : sum;
      c_data_in.neg    = b_neg_ff;
      c_data_in.bad    = b_bad_ff;
      for (int i = 0; i < NUM_DIRS; i++) begin
         c_data_in.lane[i].rem  = RES_W'({b_sq_ff[i], {COMP_SHIFT{1'b0}}} >> FEED_W);
         c_data_in.lane[i].feed = FEED_W'({b_sq_ff[i], {COMP_SHIFT{1'b0}}});
         c_data_in.lane[i].acc  = '0;
         c_data_in.lane[i].root = '0;
      end
      c_data_in.lane[LANE_WEIGHT].rem  = RES_W'({b_wsq_ff, {WEIGHT_SHIFT{1'b0}}} >> FEED_W);
      c_data_in.lane[LANE_WEIGHT].feed = FEED_W'({b_wsq_ff, {WEIGHT_SHIFT{1'b0}}});
      c_data_in.lane[LANE_WEIGHT].acc  = '0;
      c_data_in.lane[LANE_WEIGHT].root = '0;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= req.valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_mag_ff <= a_mag_in;
         a_neg_ff <= a_neg_in;
         a_w_ff   <= a_w_in;
         a_bad_ff <= a_bad_in;
      end
      if (b_ready) begin
         b_sq_ff  <= b_sq_in;
         b_wsq_ff <= b_wsq_in;
         b_neg_ff <= a_neg_ff;
         b_bad_ff <= a_bad_ff;
      end
      if (c_ready) begin
         c_data_ff <= c_data_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_data_ff;

endmodule

[rtl/ctd_cell.sv]
// ----------------------------------------------------------------------------
// ctd_cell
// One digit step of the ratio square root, on all four lanes: brings in two
// bits of N, tests against s*(4t+1) and decides one bit of t.
// ----------------------------------------------------------------------------
module ctd_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  ctd_pkg::cell_data_type  in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output ctd_pkg::cell_data_type  out_data
);
   import ctd_pkg::*;

   logic          valid_ff;
   cell_data_type data_ff, data_in;
   logic [NUM_LANES-1:0][RES_W-1:0] shifted, trial;
   logic [NUM_LANES-1:0]            fits;
   logic [RES_W-1:0]                s_ext;

   assign in_ready = !valid_ff || out_ready;

   // Digit step per lane: rem' = 4*rem + next bits, try s*(4t+1) = 4*acc + s
   always_comb begin
      s_ext          = RES_W'(in_data.sum_sq);
      data_in.sum_sq = in_data.sum_sq;
      data_in.neg    = in_data.neg;
      data_in.bad    = in_data.bad;
      for (int l = 0; l < NUM_LANES; l++) begin
         shifted[l] = {in_data.lane[l].rem[RES_W-3:0], in_data.lane[l].feed[FEED_W-1 -: 2]};
         trial[l]   = {in_data.lane[l].acc[RES_W-3:0], 2'b00} + s_ext;
         fits[l]    = (shifted[l] >= trial[l]);
         data_in.lane[l].rem  = fits[l] ? shifted[l] - trial[l] : shifted[l];
         data_in.lane[l].acc  = {in_data.lane[l].acc[RES_W-2:0], 1'b0}
                                + (fits[l] ? s_ext : '0);
         data_in.lane[l].root = {in_data.lane[l].root[ROOT_W-2:0], fits[l]};
         data_in.lane[l].feed = {in_data.lane[l].feed[FEED_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/ctd_round.sv]
// ----------------------------------------------------------------------------
// ctd_round
// Output stage: q = (t + 1) / 2 rounds each lane to nearest, applies the sign
// and saturation, and holds the result for the response channel.
// ----------------------------------------------------------------------------
module ctd_round (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  ctd_pkg::cell_data_type  in_data,
   ctd_rsp_if.source               rsp
);
   import ctd_pkg::*;

   logic                           valid_ff;
   logic [NUM_DIRS-1:0][DIR_W-1:0] dir_ff, dir_in;
   logic [WT_W-1:0]                weight_ff, weight_in;
   logic                           bad_ff;
   logic [NUM_LANES-1:0][ROOT_W:0] bumped;
   logic [NUM_LANES-1:0][ROOT_W-1:0] q;

   assign in_ready = !valid_ff || rsp.ready;

   // Round half up, then sign and saturate
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         bumped[l] = {1'b0, in_data.lane[l].root} + (ROOT_W+1)'(1);
         q[l]      = bumped[l][ROOT_W:1];
      end
      for (int i = 0; i < NUM_DIRS; i++) begin
         if (in_data.bad) begin
            dir_in[i] = '0;
         end else if (in_data.neg[i]) begin
            dir_in[i] = DIR_W'(-q[i]);
         end else begin
            dir_in[i] = (q[i] > ROOT_W'(DIR_POS_MAX)) ? DIR_POS_MAX : DIR_W'(q[i]);
         end
      end
      if (in_data.bad) begin
         weight_in = '0;
      end else begin
         weight_in = (q[LANE_WEIGHT] > ROOT_W'(WT_MAX)) ? WT_MAX : WT_W'(q[LANE_WEIGHT]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         dir_ff    <= dir_in;
         weight_ff <= weight_in;
         bad_ff    <= in_data.bad;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.dir_x        = dir_ff[0];
   assign rsp.dir_y        = dir_ff[1];
   assign rsp.dir_z        = dir_ff[2];
   assign rsp.solid_weight = weight_ff;
   assign rsp.bad_face     = bad_ff;

endmodule

[rtl/cube_texel_direction.sv]
// ----------------------------------------------------------------------------
// cube_texel_direction
// Cube-map texel to unit direction and solid-angle weight.
// ----------------------------------------------------------------------------
// Takes texel requests (column, row, face) and returns the unit direction
// through the texel centre in signed Q1.15 plus face_size / length in unsigned
// Q0.16, rounded to nearest and saturated; faces 6 and 7 return zeros with
// bad_face set. Throughput is one request per cycle unless a stalled response
// backs the pipe up. The pipe is three setup stages (vector, squares, sum), a
// row of 18 root cells that each resolve one bit of floor(sqrt(N / s)) for
// all four outputs, and one rounding/output register.
// A stalled response only holds back the stages behind it; empty stages
// keep accepting. face_size (reset 256, values above 2048 act as 2048) is
// written over the csr port, which is always ready, and should change only
// while no request is in flight.
// ----------------------------------------------------------------------------
module cube_texel_direction (
   input  logic     clock,
   input  logic     reset,
   ctd_req_if.sink  req_port,
   ctd_rsp_if.source rsp_port,
   ctd_csr_if.sink  csr_port
);
   import ctd_pkg::*;

   logic [FACE_W-1:0] face_size_ff;

   logic          chain_valid [NUM_CELLS+1];
   logic          chain_ready [NUM_CELLS+1];
   cell_data_type chain_data  [NUM_CELLS+1];

   // face_size register
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff <= FACE_W'(FACE_SIZE_RST);
      end else if (csr_port.valid) begin
         face_size_ff <= csr_port.face_size;
      end
   end

   // Vector setup
   ctd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_port),
      .face_size (face_size_ff),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // Root cells, one result bit each
   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      ctd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   // Rounding and response register
   ctd_round u_round (
      .clock    (clock),
      .reset    (reset),
      .in_valid (chain_valid[NUM_CELLS]),
      .in_ready (chain_ready[NUM_CELLS]),
      .in_data  (chain_data[NUM_CELLS]),
      .rsp      (rsp_port)
   );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cube texel direction block.
// ----------------------------------------------------------------------------
// Texel requests go in over the request channel. Each one is scored against
// a bit-exact integer predictor of the unit direction and the solid-angle
// weight. A short directed table covers the saturated axes, the invalid faces,
// zero and oversized face sizes and texels past the face edge. Random phases
// follow, each with its own face_size and one of four idling patterns. One phase
// holds off the response side long enough to back the pipe up. Another
// drains the pipe partway through.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ctd_pkg::*;

   // Expected response fields
   typedef struct packed {
      logic [DIR_W-1:0] dir_x;
      logic [DIR_W-1:0] dir_y;
      logic [DIR_W-1:0] dir_z;
      logic [WT_W-1:0]  solid_weight;
      logic             bad_face;
   } dir_result_type;

   // One row of the directed table
   typedef struct packed {
      logic                  set_size;   // write face_size before this request
      logic [FACE_W-1:0]     size;
      logic [COORD_W-1:0]    col;
      logic [COORD_W-1:0]    row;
      logic [FACE_SEL_W-1:0] face;
      logic                  typed;      // use result below, not the predictor
      dir_result_type        result;
   } texel_case_type;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   localparam logic [FACE_SEL_W-1:0] FACE_BAD_6 = 3'd6;
   localparam logic [FACE_SEL_W-1:0] FACE_BAD_7 = 3'd7;
   localparam logic [DIR_W-1:0]      DIR_NEG_MAX = {1'b1, {(DIR_W-1){1'b0}}};

   localparam dir_result_type RESULT_NONE = '0;
   localparam dir_result_type RESULT_BAD  = '{'0, '0, '0, '0, 1'b1};
   localparam dir_result_type AXIS_POS_X  = '{DIR_POS_MAX, '0, '0, WT_MAX, 1'b0};
   localparam dir_result_type AXIS_NEG_X  = '{DIR_NEG_MAX, '0, '0, WT_MAX, 1'b0};
   localparam dir_result_type AXIS_POS_Y  = '{'0, DIR_POS_MAX, '0, WT_MAX, 1'b0};
   localparam dir_result_type AXIS_NEG_Y  = '{'0, DIR_NEG_MAX, '0, WT_MAX, 1'b0};
   localparam dir_result_type AXIS_POS_Z  = '{'0, '0, DIR_POS_MAX, WT_MAX, 1'b0};
   localparam dir_result_type AXIS_NEG_Z  = '{'0, '0, DIR_NEG_MAX, WT_MAX, 1'b0};

   localparam int NUM_DIRECTED = 26;
   localparam texel_case_type DIRECTED_CASES [NUM_DIRECTED] = '{
      // reset face_size, corners and invalid faces
      '{1'b0, 12'd0,    11'd0,    11'd0,    FACE_POS_X, 1'b0, RESULT_NONE},
      '{1'b0, 12'd0,    11'd255,  11'd255,  FACE_NEG_Z, 1'b0, RESULT_NONE},
      '{1'b0, 12'd0,    11'd2047, 11'd2047, FACE_BAD_7, 1'b1, RESULT_BAD},
      '{1'b0, 12'd0,    11'd0,    11'd0,    FACE_BAD_6, 1'b1, RESULT_BAD},
      // every face at one texel
      '{1'b0, 12'd0,    11'd17,   11'd200,  FACE_POS_X, 1'b0, RESULT_NONE},
      '{1'b0, 12'd0,    11'd17,   11'd200,  FACE_NEG_X, 1'b0, RESULT_NONE},
      '{1'b0, 12'd0,    11'd17,   11'd200,  FACE_POS_Y, 1'b0, RESULT_NONE},
      '{1'b0, 12'd0,    11'd17,   11'd200,  FACE_NEG_Y, 1'b0, RESULT_NONE},
      '{1'b0, 12'd0,    11'd17,   11'd200,  FACE_POS_Z, 1'b0, RESULT_NONE},
      '{1'b0, 12'd0,    11'd17,   11'd200,  FACE_NEG_Z, 1'b0, RESULT_NONE},
      // one-texel face: exact unit axes, saturated weight
      '{1'b1, 12'd1,    11'd0,    11'd0,    FACE_POS_X, 1'b1, AXIS_POS_X},
      '{1'b0, 12'd0,    11'd0,    11'd0,    FACE_NEG_X, 1'b1, AXIS_NEG_X},
      '{1'b0, 12'd0,    11'd0,    11'd0,    FACE_POS_Y, 1'b1, AXIS_POS_Y},
      '{1'b0, 12'd0,    11'd0,    11'd0,    FACE_NEG_Y, 1'b1, AXIS_NEG_Y},
      '{1'b0, 12'd0,    11'd0,    11'd0,    FACE_POS_Z, 1'b1, AXIS_POS_Z},
      '{1'b0, 12'd0,    11'd0,    11'd0,    FACE_NEG_Z, 1'b1, AXIS_NEG_Z},
      // largest face
      '{1'b1, 12'd2048, 11'd0,    11'd0,    FACE_POS_X, 1'b0, RESULT_NONE},
      '{1'b0, 12'd0,    11'd2047, 11'd2047, FACE_POS_Z, 1'b0, RESULT_NONE},
      '{1'b0, 12'd0,    11'd1024, 11'd1023, FACE_POS_Y, 1'b0, RESULT_NONE},
      // oversized face_size clips to the largest face
      '{1'b1, 12'd4095, 11'd2047, 11'd0,    FACE_NEG_Y, 1'b0, RESULT_NONE},
      '{1'b0, 12'd0,    11'd0,    11'd2047, FACE_NEG_Z, 1'b0, RESULT_NONE},
      // zero face_size
      '{1'b1, 12'd0,    11'd0,    11'd0,    FACE_POS_X, 1'b0, RESULT_NONE},
      '{1'b0, 12'd0,    11'd2047, 11'd2047, FACE_NEG_X, 1'b0, RESULT_NONE},
      // centre of an odd face
      '{1'b1, 12'd5,    11'd2,    11'd2,    FACE_POS_Z, 1'b1, AXIS_POS_Z},
      // texel far past the face edge
      '{1'b1, 12'd3,    11'd2047, 11'd2047, FACE_POS_Y, 1'b0, RESULT_NONE},
      '{1'b0, 12'd0,    11'd1,    11'd1,    FACE_BAD_7, 1'b1, RESULT_BAD}
   };

   localparam int NUM_PHASES      = 8;
   localparam int PHASE_REQUESTS  = 106;
   localparam int HOLD_CYCLES     = 100;
   localparam int SETTLE_CYCLES   = 30;
   localparam logic [FACE_W-1:0] PHASE_SIZES [NUM_PHASES] = '{
      12'd2048, 12'd1, 12'd4095, 12'd0, 12'd7, 12'd256, 12'd1000, 12'd2047
   };

   logic clock;
   logic reset;

   ctd_req_if req_bus ();
   ctd_rsp_if rsp_bus ();
   ctd_csr_if csr_bus ();

   cube_texel_direction i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   dir_result_type    pending_dirs [$];   // directions still owed by the block
   dir_result_type    want;
   logic [FACE_W-1:0] cur_size = FACE_W'(FACE_SIZE_RST);
   idle_mode_type     idle_mode = IDLE_NONE;
   int                hold_token = 0;
   int                n_sent = 0;
   int                n_checked = 0;
   int                n_errors = 0;
   int                n_sizes = 1;

   // Largest q in [0, top] with q == 0 or (2q-1)^2 * s <= num2
   function automatic longint unsigned nearest_root_ratio(longint unsigned num2,
                                                          longint unsigned s,
                                                          longint unsigned top);
      longint unsigned lo, hi, mid, d;
      lo = 0;
      hi = top;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         d   = 2 * mid - 1;
         if (d * d * s <= num2) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return lo;
   endfunction

   // Rounded Q1.15 of c / sqrt(s), positive side saturated
   function automatic logic [DIR_W-1:0] unit_part(longint c, longint unsigned s);
      longint unsigned mag;
      longint          q;
      mag = (c < 0) ? -c : c;
      q   = nearest_root_ratio((mag * mag) << COMP_SHIFT, s, 32768);
      if (c < 0) begin
         q = -q;
      end else if (q > 32767) begin
         q = 32767;
      end
      return q[DIR_W-1:0];
   endfunction

   function automatic dir_result_type predict_direction(logic [COORD_W-1:0] col,
                                                        logic [COORD_W-1:0] row,
                                                        logic [FACE_SEL_W-1:0] face,
                                                        logic [FACE_W-1:0] size);
      longint          w, cl, rw, a, b, vx, vy, vz;
      longint unsigned s, wt;
      dir_result_type  r;
      w  = (size > MAX_FACE_SIZE) ? MAX_FACE_SIZE : size;
      cl = col;
      rw = row;
      a  = 2 * cl - w + 1;
      b  = w - 2 * rw - 1;
      r  = RESULT_NONE;
      case (face)
         FACE_POS_X: begin vx = w;  vy = b;  vz = -a; end
         FACE_NEG_X: begin vx = -w; vy = b;  vz = a;  end
         FACE_POS_Y: begin vx = a;  vy = w;  vz = -b; end
         FACE_NEG_Y: begin vx = a;  vy = -w; vz = b;  end
         FACE_POS_Z: begin vx = a;  vy = b;  vz = w;  end
         FACE_NEG_Z: begin vx = -a; vy = b;  vz = -w; end
         default: begin
            return RESULT_BAD;
         end
      endcase
      s = vx * vx + vy * vy + vz * vz;
      if (s == 0) begin
         s = 1;
      end
      r.dir_x = unit_part(vx, s);
      r.dir_y = unit_part(vy, s);
      r.dir_z = unit_part(vz, s);
      wt = nearest_root_ratio((w * w) << WEIGHT_SHIFT, s, 65536);
      r.solid_weight = (wt > 65535) ? WT_MAX : wt[WT_W-1:0];
      return r;
   endfunction

   function automatic void check_field(string name, int expv, int actv);
      if (expv != actv) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
         n_errors++;
      end
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

   // Response side: random stalls per phase, plus one long hold on request
   initial begin : rsp_sink
      int hold_left;
      int hold_seen;
      int stall_pct;
      hold_left = 0;
      hold_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         case (idle_mode)
            IDLE_RECV: stall_pct = 70;
            IDLE_BOTH: stall_pct = 13;
            default:   stall_pct = 0;
         endcase
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Score each accepted response against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_dirs.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0d %0d %0d %0d %0b",
                     $time, rsp_bus.dir_x, rsp_bus.dir_y, rsp_bus.dir_z,
                     rsp_bus.solid_weight, rsp_bus.bad_face);
            n_errors++;
         end else begin
            want = pending_dirs.pop_front();
            check_field("dir_x", $signed(want.dir_x), $signed(rsp_bus.dir_x));
            check_field("dir_y", $signed(want.dir_y), $signed(rsp_bus.dir_y));
            check_field("dir_z", $signed(want.dir_z), $signed(rsp_bus.dir_z));
            check_field("solid_weight", int'(want.solid_weight),
                        int'(rsp_bus.solid_weight));
            check_field("bad_face", int'(want.bad_face), int'(rsp_bus.bad_face));
            n_checked++;
         end
      end
   end

   // Offer one texel request and log its expectation once it is taken
   task automatic offer_texel(input logic [COORD_W-1:0] col,
                              input logic [COORD_W-1:0] row,
                              input logic [FACE_SEL_W-1:0] face,
                              input logic typed,
                              input dir_result_type typed_result);
      int gap_pct;
      case (idle_mode)
         IDLE_SEND: gap_pct = 70;
         IDLE_BOTH: gap_pct = 13;
         default:   gap_pct = 0;
      endcase
      while ($urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.texel_col <= col;
      req_bus.texel_row <= row;
      req_bus.face      <= face;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_dirs.push_back(typed ? typed_result
                                   : predict_direction(col, row, face, cur_size));
      n_sent++;
   endtask

   // Stop sending and wait until every response is back
   task automatic drain_pipe();
      req_bus.valid <= 1'b0;
      while (pending_dirs.size() != 0) @(posedge clock);
   endtask

   task automatic write_face_size(input logic [FACE_W-1:0] size);
      csr_bus.valid     <= 1'b1;
      csr_bus.face_size <= size;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      cur_size = size;
      n_sizes++;
   endtask

   // Stimulus
   initial begin : stimulus
      texel_case_type        tc;
      int                    p, k, pick;
      int unsigned           weff;
      logic [COORD_W-1:0]    col, row;
      logic [FACE_SEL_W-1:0] face;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.texel_col <= '0;
      req_bus.texel_row <= '0;
      req_bus.face      <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.face_size <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (k = 0; k < NUM_DIRECTED; k++) begin
         tc = DIRECTED_CASES[k];
         if (tc.set_size) begin
            drain_pipe();
            write_face_size(tc.size);
         end
         offer_texel(tc.col, tc.row, tc.face, tc.typed, tc.result);
      end

      // random phases, mostly texels inside the face
      for (p = 0; p < NUM_PHASES; p++) begin
         drain_pipe();
         write_face_size(PHASE_SIZES[p]);
         idle_mode = idle_mode_type'(p % 4);
         for (k = 0; k < PHASE_REQUESTS; k++) begin
            // long response hold while the sender keeps pushing
            if (p == 0 && k == 30) begin
               hold_token <= hold_token + 1;
            end
            // sender pause until the pipe is empty
            if (p == 5 && k == 50) begin
               drain_pipe();
            end
            weff = (cur_size > MAX_FACE_SIZE) ? MAX_FACE_SIZE : cur_size;
            pick = $urandom_range(99);
            if (pick < 80 && weff != 0) begin
               col  = COORD_W'($urandom_range(weff - 1, 0));
               row  = COORD_W'($urandom_range(weff - 1, 0));
               face = FACE_SEL_W'($urandom_range(5, 0));
            end else if (pick < 93) begin
               col  = COORD_W'($urandom);
               row  = COORD_W'($urandom);
               face = FACE_SEL_W'($urandom_range(5, 0));
            end else begin
               col  = COORD_W'($urandom);
               row  = COORD_W'($urandom);
               face = FACE_SEL_W'($urandom_range(FACE_BAD_7, FACE_BAD_6));
            end
            offer_texel(col, row, face, 1'b0, RESULT_NONE);
         end
      end

      drain_pipe();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d responses for %0d texel requests over %0d face_size settings,",
               n_checked, n_sent, n_sizes);
      $display("with invalid faces, off-face texels, a long output stall and a mid-run drain.");
      if (n_errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
